// ----- hw/rtl/mbc1_pkg.sv -----
// Shared constants and types of the MBC1 bank controller.
package mbc1_pkg;

    localparam int RamBytes     = 8192;
    localparam int RomBankBytes = 16384;
    localparam int RamAw        = $clog2(RamBytes);
    localparam int RomOffW      = $clog2(RomBankBytes);
    localparam int BankW        = 7;
    localparam int RomAddrW     = BankW + RomOffW;

    localparam int Bound2k = (RamBytes < 2048) ? RamBytes : 2048;
    localparam int Bound8k = (RamBytes < 8192) ? RamBytes : 8192;

    localparam logic        OpRead    = 1'b0;
    localparam logic        OpWrite   = 1'b1;
    localparam logic        CfgHasRam = 1'b0;
    localparam logic        CfgRamSz  = 1'b1;
    localparam logic [1:0]  SizeNone  = 2'd0;
    localparam logic [1:0]  Size2k    = 2'd1;
    localparam logic [1:0]  Size8k    = 2'd2;
    localparam logic [3:0]  RamKey    = 4'hA;
    localparam logic [15:0] RamBase   = 16'hA000;
    localparam logic [7:0]  OpenBus   = 8'hFF;

    typedef struct packed {
        logic                ram_rd;
        logic                ram_wr;
        logic [RamAw-1:0]    ram_idx;
        logic                rom_hit;
        logic [RomAddrW-1:0] rom_addr;
    } t_access;

endpackage

// ----- hw/rtl/mbc1_ram.sv -----
// Generic single-port RAM with registered read.
module mbc1_ram #(
    parameter int Width = 8,
    parameter int Depth = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/mbc1_ctrl.sv -----
// Bank and configuration registers with bus access decode.
module mbc1_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic                 i_op,
    input  logic [15:0]          i_address,
    input  logic [7:0]           i_write_data,
    input  logic                 i_cfg_fire,
    input  logic                 i_cfg_index,
    input  logic [1:0]           i_cfg_data,
    output mbc1_pkg::t_access    o_access
);

    logic       r_has_ram, n_has_ram;
    logic [1:0] r_ram_size, n_ram_size;
    logic       r_ram_on, n_ram_on;
    logic [4:0] r_bank_low, n_bank_low;
    logic [1:0] r_bank_high, n_bank_high;
    logic       r_mode, n_mode;

    logic [15:0] ram_off;
    logic [15:0] ram_bound;
    logic        ram_ok;
    logic [mbc1_pkg::BankW-1:0] bank;

    always_comb begin
        unique case (r_ram_size)
            mbc1_pkg::SizeNone: ram_bound = 16'd0;
            mbc1_pkg::Size2k:   ram_bound = 16'(mbc1_pkg::Bound2k);
            default:            ram_bound = 16'(mbc1_pkg::Bound8k);
        endcase
    end

    assign ram_off = i_address - mbc1_pkg::RamBase;
    assign ram_ok  = (i_address[15:13] == 3'b101) && r_has_ram && r_ram_on
                     && (ram_off < ram_bound);
    assign bank    = r_mode ? {2'b00, r_bank_low} : {r_bank_high, r_bank_low};

    always_comb begin
        o_access.ram_rd   = (i_op == mbc1_pkg::OpRead) && ram_ok;
        o_access.ram_wr   = (i_op == mbc1_pkg::OpWrite) && ram_ok;
        o_access.ram_idx  = ram_off[mbc1_pkg::RamAw-1:0];
        o_access.rom_hit  = (i_op == mbc1_pkg::OpRead) && !i_address[15];
        o_access.rom_addr = '0;
        if (o_access.rom_hit) begin
            if (i_address[14]) begin
                o_access.rom_addr = {bank, i_address[mbc1_pkg::RomOffW-1:0]};
            end else begin
                o_access.rom_addr = {{mbc1_pkg::BankW{1'b0}},
                                     i_address[mbc1_pkg::RomOffW-1:0]};
            end
        end
    end

    always_comb begin
        n_has_ram   = r_has_ram;
        n_ram_size  = r_ram_size;
        n_ram_on    = r_ram_on;
        n_bank_low  = r_bank_low;
        n_bank_high = r_bank_high;
        n_mode      = r_mode;
        if (i_cfg_fire) begin
            unique case (i_cfg_index)
                mbc1_pkg::CfgHasRam: n_has_ram  = i_cfg_data[0];
                mbc1_pkg::CfgRamSz:  n_ram_size = i_cfg_data;
                default:             n_has_ram  = r_has_ram;
            endcase
        end
        if (i_fire && (i_op == mbc1_pkg::OpWrite) && !i_address[15]) begin
            unique case (i_address[14:13])
                2'd0: n_ram_on = (i_write_data[3:0] == mbc1_pkg::RamKey);
                2'd1: n_bank_low = (i_write_data[4:0] == 5'd0) ? 5'd1
                                                                : i_write_data[4:0];
                2'd2: n_bank_high = i_write_data[1:0];
                default: n_mode = i_write_data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_ram   <= 1'b1;
            r_ram_size  <= mbc1_pkg::Size8k;
            r_ram_on    <= 1'b0;
            r_bank_low  <= 5'd1;
            r_bank_high <= 2'd0;
            r_mode      <= 1'b0;
        end else begin
            r_has_ram   <= n_has_ram;
            r_ram_size  <= n_ram_size;
            r_ram_on    <= n_ram_on;
            r_bank_low  <= n_bank_low;
            r_bank_high <= n_bank_high;
            r_mode      <= n_mode;
        end
    end

endmodule

// ----- hw/rtl/mbc1_bank_controller_unit.sv -----
// Top level of the MBC1 bank controller: access pipeline and result register.
// One bus access is accepted per cycle unless back-pressure holds the input side,
// and each gives one result word: the access is decoded and the RAM read issued
// when it is accepted, and the registered RAM read data is captured into the
// result register once that register can load. Back-pressure on the result side
// stalls the input side once both stages are full. Control register writes take
// effect for the next access. Configuration writes are always accepted; index 0
// is has_ram, index 1 is ram_size. RAM content is undefined until written; there
// is no clearing pass.
module mbc1_bank_controller_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [15:0]                   i_address,
    input  logic [7:0]                    i_write_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_read_data,
    output logic                          o_rom_access,
    output logic [mbc1_pkg::RomAddrW-1:0] o_rom_address,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [1:0]                    i_cfg_data
);

    mbc1_pkg::t_access access;

    logic       in_fire;
    logic       out_load;
    logic [7:0] ram_q;

    logic                          r_s1_valid;
    logic                          r_s1_ram_rd;
    logic                          r_s1_rom_hit;
    logic [mbc1_pkg::RomAddrW-1:0] r_s1_rom_addr;
    logic                          r_out_valid;
    logic [7:0]                    r_out_data;
    logic                          r_out_rom;
    logic [mbc1_pkg::RomAddrW-1:0] r_out_addr;

    assign out_load    = !r_out_valid || i_ready;
    assign o_ready     = !r_s1_valid || out_load;
    assign in_fire     = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    mbc1_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_op         (i_op),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_cfg_fire   (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_access     (access)
    );

    mbc1_ram #(
        .Width (8),
        .Depth (mbc1_pkg::RamBytes)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && access.ram_wr),
        .i_re    (in_fire && access.ram_rd),
        .i_addr  (access.ram_idx),
        .i_wdata (i_write_data),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_ram_rd   <= access.ram_rd;
            r_s1_rom_hit  <= access.rom_hit;
            r_s1_rom_addr <= access.rom_addr;
        end
        if (out_load && r_s1_valid) begin
            r_out_data <= r_s1_ram_rd ? ram_q : mbc1_pkg::OpenBus;
            r_out_rom  <= r_s1_rom_hit;
            r_out_addr <= r_s1_rom_addr;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_data   = r_out_data;
    assign o_rom_access  = r_out_rom;
    assign o_rom_address = r_out_addr;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench of the MBC1 bank controller: directed and random bus accesses with handshake gaps.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [15:0] RegBankLo = 16'h2000;
    localparam logic [15:0] RegBankHi = 16'h4000;
    localparam logic [15:0] RegMode   = 16'h6000;
    localparam logic [15:0] RomTop    = 16'h8000;
    localparam logic [15:0] RamEnd    = 16'hBFFF;
    localparam logic [1:0]  SizeSpare = 2'd3;
    localparam int          Phases    = 6;
    localparam int          PhaseLen  = 200;

    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_bus_access;

    typedef struct packed {
        logic [7:0]                    read_data;
        logic                          rom_access;
        logic [mbc1_pkg::RomAddrW-1:0] rom_address;
    } t_bus_answer;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_valid      = 1'b0;
    logic                          i_op         = mbc1_pkg::OpRead;
    logic [15:0]                   i_address    = '0;
    logic [7:0]                    i_write_data = '0;
    logic                          i_ready      = 1'b0;
    logic                          i_cfg_valid  = 1'b0;
    logic                          i_cfg_index  = mbc1_pkg::CfgHasRam;
    logic [1:0]                    i_cfg_data   = '0;
    logic                          o_ready;
    logic                          o_valid;
    logic                          o_cfg_ready;
    logic [7:0]                    o_read_data;
    logic                          o_rom_access;
    logic [mbc1_pkg::RomAddrW-1:0] o_rom_address;

    mbc1_bank_controller_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_data   (o_read_data),
        .o_rom_access  (o_rom_access),
        .o_rom_address (o_rom_address),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mapper state as the block should hold it
    logic             cfg_has_ram = 1'b1;
    logic [1:0]       cfg_ram_size = mbc1_pkg::Size8k;
    logic             ram_on = 1'b0;
    logic [4:0]       bank_low = 5'd1;
    logic [1:0]       bank_high = 2'd0;
    logic             ram_mode = 1'b0;
    logic [7:0]       ram_mem [mbc1_pkg::RamBytes];

    // stimulus-side view, used only to keep reads off unwritten RAM
    logic             gen_ram_on = 1'b0;
    bit               gen_written [mbc1_pkg::RamBytes];
    int unsigned      written_offs [$];

    t_bus_access      access_q [$];
    t_bus_answer      answer_q [$];
    t_bus_access      next_acc;
    t_bus_answer      want;
    int unsigned      words_queued = 0;
    int unsigned      words_taken = 0;
    int unsigned      mismatches = 0;
    int unsigned      gap_left = 0;
    int unsigned      stall_left = 0;
    bit               calm = 1'b0;
    bit               has_tbl  [Phases] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic [1:0]       size_tbl [Phases] = '{mbc1_pkg::Size2k, SizeSpare, mbc1_pkg::Size8k,
                                            mbc1_pkg::SizeNone, mbc1_pkg::Size2k,
                                            mbc1_pkg::Size8k};

    function automatic int unsigned ram_bound();
        case (cfg_ram_size)
            mbc1_pkg::SizeNone: return 0;
            mbc1_pkg::Size2k:   return mbc1_pkg::Bound2k;
            default:            return mbc1_pkg::Bound8k;
        endcase
    endfunction

    function automatic bit ram_reach(logic [15:0] addr, logic enabled);
        int unsigned off;
        off = int'(addr) - int'(mbc1_pkg::RamBase);
        return addr >= mbc1_pkg::RamBase && addr <= RamEnd && cfg_has_ram && enabled
               && off < ram_bound();
    endfunction

    function automatic void map_access(t_bus_access a);
        t_bus_answer r;
        int unsigned off;
        logic [6:0]  bank;
        r.read_data   = mbc1_pkg::OpenBus;
        r.rom_access  = 1'b0;
        r.rom_address = '0;
        off = int'(a.addr) - int'(mbc1_pkg::RamBase);
        if (a.op == mbc1_pkg::OpWrite) begin
            if (a.addr < RegBankLo) begin
                ram_on = (a.wdata[3:0] == mbc1_pkg::RamKey);
            end else if (a.addr < RegBankHi) begin
                bank_low = (a.wdata[4:0] == 5'd0) ? 5'd1 : a.wdata[4:0];
            end else if (a.addr < RegMode) begin
                bank_high = a.wdata[1:0];
            end else if (a.addr < RomTop) begin
                ram_mode = a.wdata[0];
            end else if (ram_reach(a.addr, ram_on)) begin
                ram_mem[off] = a.wdata;
            end
        end else begin
            if (a.addr < RegBankHi) begin
                r.rom_access  = 1'b1;
                r.rom_address = mbc1_pkg::RomAddrW'(a.addr);
            end else if (a.addr < RomTop) begin
                bank = {ram_mode ? 2'b00 : bank_high, bank_low};
                r.rom_access  = 1'b1;
                r.rom_address = {bank, a.addr[mbc1_pkg::RomOffW-1:0]};
            end else if (ram_reach(a.addr, ram_on)) begin
                r.read_data = ram_mem[off];
            end
        end
        answer_q.push_back(r);
    endfunction

    function automatic void queue_access(logic op, logic [15:0] addr, logic [7:0] wdata);
        t_bus_access a;
        int unsigned off;
        off = int'(addr) - int'(mbc1_pkg::RamBase);
        // a read that would land on a never-written byte becomes a write
        if (op == mbc1_pkg::OpRead && ram_reach(addr, gen_ram_on) && !gen_written[off])
            op = mbc1_pkg::OpWrite;
        if (op == mbc1_pkg::OpWrite) begin
            if (addr < RegBankLo) begin
                gen_ram_on = (wdata[3:0] == mbc1_pkg::RamKey);
            end else if (ram_reach(addr, gen_ram_on)) begin
                if (!gen_written[off])
                    written_offs.push_back(off);
                gen_written[off] = 1'b1;
            end
        end
        a.op    = op;
        a.addr  = addr;
        a.wdata = wdata;
        access_q.push_back(a);
        words_queued++;
    endfunction

    function automatic void queue_random_access();
        logic        op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        int unsigned off;
        op    = 1'($urandom_range(0, 1));
        addr  = 16'($urandom());
        wdata = 8'($urandom());
        case ($urandom_range(0, 9))
            0: begin
                op   = mbc1_pkg::OpRead;
                addr = 16'($urandom_range(0, 16'h3FFF));
            end
            1, 2: begin
                op   = mbc1_pkg::OpRead;
                addr = 16'($urandom_range(16'h4000, 16'h7FFF));
            end
            3: begin
                op   = mbc1_pkg::OpWrite;
                addr = 16'($urandom_range(RegBankLo, RegMode - 1));
            end
            4: begin
                op   = mbc1_pkg::OpWrite;
                addr = 16'($urandom_range(0, RegBankLo - 1));
                if ($urandom_range(0, 3) != 0)
                    wdata[3:0] = mbc1_pkg::RamKey;
            end
            5: begin
                op   = mbc1_pkg::OpWrite;
                addr = 16'($urandom_range(RegMode, RomTop - 1));
            end
            6, 7: begin
                if (op == mbc1_pkg::OpRead && written_offs.size() > 0
                    && $urandom_range(0, 9) < 7) begin
                    off = written_offs[$urandom_range(0, written_offs.size() - 1)];
                end else begin
                    case ($urandom_range(0, 5))
                        0:       off = 0;
                        1:       off = mbc1_pkg::Bound2k - 1;
                        2:       off = mbc1_pkg::Bound2k;
                        3:       off = mbc1_pkg::Bound8k - 1;
                        default: off = $urandom_range(0, mbc1_pkg::RamBytes - 1);
                    endcase
                end
                addr = mbc1_pkg::RamBase + 16'(off);
            end
            8: begin
                addr = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(16'h8000, 16'h9FFF))
                                                   : 16'($urandom_range(16'hC000, 16'hFFFF));
            end
            default: ;
        endcase
        queue_access(op, addr, wdata);
    endfunction

    task automatic write_cfg(logic idx, logic [1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == mbc1_pkg::CfgHasRam)
            cfg_has_ram = val[0];
        else
            cfg_ram_size = val;
    endtask

    task automatic drain();
        while (words_taken != words_queued || answer_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && o_ready) begin
                map_access('{op: i_op, addr: i_address, wdata: i_write_data});
                words_taken++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 13);
                    i_valid <= 1'b0;
                end else if (access_q.size() > 0) begin
                    next_acc = access_q.pop_front();
                    i_valid      <= 1'b1;
                    i_op         <= next_acc.op;
                    i_address    <= next_acc.addr;
                    i_write_data <= next_acc.wdata;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // answer side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (answer_q.size() == 0) begin
                    $error("unexpected answer word: read_data %h rom_access %b rom_address %h",
                           o_read_data, o_rom_access, o_rom_address);
                    mismatches++;
                end else begin
                    want = answer_q.pop_front();
                    if (o_read_data !== want.read_data) begin
                        $error("read_data: expected %h, got %h", want.read_data, o_read_data);
                        mismatches++;
                    end
                    if (o_rom_access !== want.rom_access) begin
                        $error("rom_access: expected %b, got %b", want.rom_access, o_rom_access);
                        mismatches++;
                    end
                    if (o_rom_address !== want.rom_address) begin
                        $error("rom_address: expected %h, got %h",
                               want.rom_address, o_rom_address);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 13);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fixed window ends, default bank, RAM still off
        queue_access(mbc1_pkg::OpRead, 16'h0000, 8'h00);
        queue_access(mbc1_pkg::OpRead, 16'h3FFF, 8'hFF);
        queue_access(mbc1_pkg::OpRead, 16'h4000, 8'h00);
        queue_access(mbc1_pkg::OpRead, 16'h7FFF, 8'h00);
        queue_access(mbc1_pkg::OpRead, 16'hA000, 8'h00);
        // bank zero maps to one, then the top bank
        queue_access(mbc1_pkg::OpWrite, 16'h2000, 8'h00);
        queue_access(mbc1_pkg::OpRead, 16'h4000, 8'h00);
        queue_access(mbc1_pkg::OpWrite, 16'h3FFF, 8'hFF);
        queue_access(mbc1_pkg::OpWrite, 16'h4000, 8'hFF);
        queue_access(mbc1_pkg::OpRead, 16'h7FFF, 8'h00);
        // RAM banking mode drops the upper bits
        queue_access(mbc1_pkg::OpWrite, 16'h6000, 8'h01);
        queue_access(mbc1_pkg::OpRead, 16'h5555, 8'h00);
        queue_access(mbc1_pkg::OpWrite, 16'h7FFF, 8'hFE);
        // RAM on, both ends of the window
        queue_access(mbc1_pkg::OpWrite, 16'h0000, 8'h0A);
        queue_access(mbc1_pkg::OpWrite, 16'hA000, 8'h00);
        queue_access(mbc1_pkg::OpWrite, 16'hBFFF, 8'hFF);
        queue_access(mbc1_pkg::OpRead, 16'hA000, 8'h00);
        queue_access(mbc1_pkg::OpRead, 16'hBFFF, 8'h00);
        // only the low nibble counts for enable
        queue_access(mbc1_pkg::OpWrite, 16'h1FFF, 8'hA0);
        queue_access(mbc1_pkg::OpRead, 16'hBFFF, 8'h00);
        queue_access(mbc1_pkg::OpWrite, 16'h1FFF, 8'h5A);
        // unmapped areas
        queue_access(mbc1_pkg::OpWrite, 16'h9FFF, 8'h55);
        queue_access(mbc1_pkg::OpRead, 16'h8000, 8'h00);
        queue_access(mbc1_pkg::OpWrite, 16'hFFFF, 8'hAA);
        queue_access(mbc1_pkg::OpRead, 16'hC000, 8'h00);
        drain();

        for (int p = 0; p < Phases; p++) begin
            write_cfg(mbc1_pkg::CfgHasRam, {1'b0, has_tbl[p]});
            write_cfg(mbc1_pkg::CfgRamSz, size_tbl[p]);
            if (p == Phases - 1)
                calm = 1'b1;
            repeat (PhaseLen) queue_random_access();
            drain();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/mbc1_pkg.sv
hw/rtl/mbc1_ram.sv
hw/rtl/mbc1_ctrl.sv
hw/rtl/mbc1_bank_controller_unit.sv
bench/tb_top.sv
